>>> rtl/core/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Holds the job record passed from the front end through the queue to the back end.
// No dependencies.
package u8d_pkg;

   // Width of a decoded code point.
   localparam int CP_W = 21;

   // Width of the replacement count in one job; a byte causes at most four replacements.
   localparam int REP_W = 3;

   // Default number of jobs the queue between front and back end holds.
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Replacement character emitted for every decoding error.
   localparam logic [CP_W-1:0] REPLACEMENT_CHAR = CP_W'(21'h00FFFD);

   // Work for the back end caused by one input byte: first n_rep replacement
   // characters, then the decoded value when has_value is set.
   typedef struct packed {
      logic [REP_W-1:0] n_rep;
      logic             has_value;
      logic [CP_W-1:0]  value;
   } job_type;

endpackage

>>> rtl/core/u8d_front.sv
// Front end of the UTF-8 stream decoder: classifies each byte and tracks the open sequence.
// Produces one job per byte that causes results, for the queue.
// Depends on u8d_pkg.
module u8d_front import u8d_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    data_byte,
   input  logic [1:0]    bytes_after,
   output logic          push,
   output job_type       push_job
);

   typedef enum logic [1:0] {
      LEAD_ASCII,
      LEAD_MULTI,
      LEAD_BAD
   } lead_kind_type;

   typedef struct packed {
      lead_kind_type   kind;
      logic [1:0]      extra;
      logic [CP_W-1:0] bits;
   } lead_info_type;

   // Decode the lead-byte prefix into its kind, continuation count and payload bits.
   function automatic lead_info_type classify_lead(input logic [7:0] b);
      lead_info_type info;
      info.kind  = LEAD_BAD;
      info.extra = 2'd0;
      info.bits  = '0;
      if (b[7] == 1'b0) begin
         info.kind = LEAD_ASCII;
         info.bits = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
         info.kind  = LEAD_MULTI;
         info.extra = 2'd1;
         info.bits  = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         info.kind  = LEAD_MULTI;
         info.extra = 2'd2;
         info.bits  = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         info.kind  = LEAD_MULTI;
         info.extra = 2'd3;
         info.bits  = {18'd0, b[2:0]};
      end
      return info;
   endfunction

   logic [1:0]      need_ff, need_in;
   logic [1:0]      acc_ff, acc_in;
   logic [CP_W-1:0] pv_ff, pv_in;
   logic            disc_ff, disc_in;
   job_type         job;

   // Next state and job for the byte on the input.
   always_comb begin
      lead_info_type   lead;
      logic            run_lead;
      logic [1:0]      acc_next;
      logic [CP_W-1:0] pv_next;
      need_in       = need_ff;
      acc_in        = acc_ff;
      pv_in         = pv_ff;
      disc_in       = disc_ff;
      job.n_rep     = '0;
      job.has_value = 1'b0;
      job.value     = '0;
      run_lead      = 1'b0;
      lead          = classify_lead(data_byte);
      acc_next      = acc_ff + 2'd1;
      pv_next       = {pv_ff[CP_W-7:0], data_byte[5:0]};

      if (disc_ff) begin
         // Dropping the rest of a string; a string end ends the drop.
         if (bytes_after == 2'd0) begin
            disc_in = 1'b0;
         end
      end else if (need_ff != 2'd0) begin
         if (data_byte[7:6] == 2'b10) begin
            // Continuation: shift in six bits, emit when the sequence is complete.
            if (acc_next >= need_ff) begin
               job.has_value = 1'b1;
               job.value     = pv_next;
               need_in       = 2'd0;
               acc_in        = 2'd0;
               pv_in         = '0;
            end else begin
               acc_in = acc_next;
               pv_in  = pv_next;
            end
         end else begin
            // Broken sequence: one replacement for the lead and one per accepted
            // continuation, then the byte is taken as a lead.
            job.n_rep = (acc_ff >= 2'd2) ? REP_W'(3) : REP_W'({1'b0, acc_ff} + 3'd1);
            need_in   = 2'd0;
            acc_in    = 2'd0;
            pv_in     = '0;
            run_lead  = 1'b1;
         end
      end else begin
         run_lead = 1'b1;
      end

      // Lead byte handling.
      if (run_lead) begin
         case (lead.kind)
            LEAD_ASCII: begin
               job.has_value = 1'b1;
               job.value     = lead.bits;
            end
            LEAD_MULTI: begin
               if (lead.extra > bytes_after) begin
                  job.n_rep = job.n_rep + REP_W'(1);
                  if (bytes_after != 2'd0) begin
                     disc_in = 1'b1;
                  end
               end else begin
                  need_in = lead.extra;
                  acc_in  = 2'd0;
                  pv_in   = lead.bits;
               end
            end
            default: begin
               job.n_rep = job.n_rep + REP_W'(1);
            end
         endcase
      end
   end

   assign push     = accept && (job.has_value || (job.n_rep != '0));
   assign push_job = job;

   // Sequence state, updated on every accepted transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff <= 2'd0;
         acc_ff  <= 2'd0;
         pv_ff   <= '0;
         disc_ff <= 1'b0;
      end else if (accept) begin
         need_ff <= need_in;
         acc_ff  <= acc_in;
         pv_ff   <= pv_in;
         disc_ff <= disc_in;
      end
   end

endmodule

>>> rtl/core/u8d_queue.sv
// Job queue between the front and back ends of the UTF-8 stream decoder.
// A small circular buffer with a fill count; head is read combinationally.
// Depends on u8d_pkg.
module u8d_queue import u8d_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   // Pointer wrap and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Queue fill count exceeds depth.");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("Job pushed into a full queue.");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("Job popped from an empty queue.");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("Fill count did not follow a lone push.");
`endif

endmodule

>>> rtl/core/u8d_back.sv
// Back end of the UTF-8 stream decoder: expands each job into result transfers.
// Drives the registered result channel, one result per cycle unless rsp_stall holds it.
// Depends on u8d_pkg.
module u8d_back import u8d_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  job_type         head_job,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [CP_W-1:0] rsp_code_point,
   output logic            rsp_last_of_run
);

   logic [REP_W-1:0] sent_ff, sent_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0]  cp_ff, cp_in;
   logic             last_ff, last_in;
   logic             load;
   logic             emit;

   // The output register takes a new result when empty or being drained.
   assign load = !rsp_valid_ff || !rsp_stall;
   assign emit = load && head_valid;

   // Select the next result of the head job.
   always_comb begin
      sent_in      = sent_ff;
      cp_in        = cp_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
      end
      if (emit) begin
         if (sent_ff < head_job.n_rep) begin
            cp_in   = REPLACEMENT_CHAR;
            last_in = ((sent_ff + REP_W'(1)) == head_job.n_rep) && !head_job.has_value;
         end else begin
            cp_in   = head_job.value;
            last_in = 1'b1;
         end
         if (last_in) begin
            pop     = 1'b1;
            sent_in = '0;
         end else begin
            sent_in = sent_ff + REP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      cp_ff   <= cp_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_point  = cp_ff;
   assign rsp_last_of_run = last_ff;

endmodule

>>> rtl/core/utf8_stream_decoder_core.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_data_byte[7:0], req_bytes_after[1:0]
// rsp      out        rsp_valid / rsp_stall  rsp_code_point[20:0], rsp_last_of_run
//
// One byte is taken every cycle while the queue has room. A byte causes zero to four results,
// sent one per cycle from the back end's output register unless rsp_stall holds them. Bursts
// of replacement characters fill the job queue (QUEUE_DEPTH jobs); req_stall rises only
// when it is full. Synchronous reset clears sequence state, queue and output.
// Top level of the UTF-8 stream decoder; instantiates front end, job queue and back end.
// Depends on u8d_pkg, u8d_front, u8d_queue and u8d_back.
module utf8_stream_decoder_core import u8d_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_data_byte,
   input  logic [1:0]      req_bytes_after,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [CP_W-1:0] rsp_code_point,
   output logic            rsp_last_of_run
);

   logic    accept;
   logic    push;
   job_type push_job;
   logic    full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   // An input transfer completes whenever the queue has room.
   assign req_stall = full;
   assign accept    = req_valid && !full;

   u8d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .bytes_after (req_bytes_after),
      .push        (push),
      .push_job    (push_job)
   );

   u8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u8d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
